[rtl/ach_pkg.sv]
// Shared constants and types for the Achilles number test block.
`default_nettype none

package ach_pkg;

    // Default width of the value under test
    localparam int VALUE_WIDTH_DEF = 31;

    // First odd trial divisor and the divisor step
    localparam int FIRST_ODD_DIV = 3;
    localparam int DIV_STEP      = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVEN,
        ST_DSTART,
        ST_DWAIT,
        ST_GCD,
        ST_FINISH
    } ach_state_t;

endpackage

`default_nettype wire

[rtl/ach_div.sv]
// Bit-serial restoring divider: one quotient bit per clock.
`default_nettype none

module ach_div #(
    parameter int VALUE_WIDTH = ach_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [VALUE_WIDTH-1:0]      remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    // divisor must stay put while busy; partial remainder < 2*divisor
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge      = (shifted >= {1'b0, divisor});
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/achilles_number_test_top.sv]
// Top level of the Achilles number test: control sequencer around a serial divider.
`default_nettype none

// Classifies one unsigned value per transaction as Achilles (powerful, not a
// perfect power) or not. The value is factored by trial division: factors of
// two are stripped one bit per clock, then odd divisors 3, 5, 7, ... are tried
// while divisor <= cofactor / divisor. Every trial is one pass of the
// bit-serial divider, and the same pass yields both the loop bound (quotient)
// and divisibility (remainder). A prime seen exactly once ends the test early
// with 0. Exponent gcd is kept by a subtractive loop on exponent-width values
// for each distinct prime. The time to a result is data dependent: zero and
// one go straight to the result, a single factor of two ends the test while
// factors of two are stripped, small values need only a short search, and the
// slowest cases are a large prime or a value with a large prime factor, whose
// odd-divisor search runs up to about sqrt(value). One transaction is
// processed at a time; in_ready is high when the sequencer is idle, and the
// result sits in an output register so a new value can be taken while the
// previous answer waits on out_ready.
module achilles_number_test_top #(
    parameter int VALUE_WIDTH = ach_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        is_achilles
);

    // exponent of any prime is below VALUE_WIDTH
    localparam int EW = $clog2(VALUE_WIDTH + 1);

    ach_pkg::ach_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;     // remaining cofactor
    logic [VALUE_WIDTH-1:0] d_reg, d_next;     // current trial divisor
    logic [EW-1:0]          e_reg, e_next;     // exponent of current prime
    logic [EW-1:0]          g_reg, g_next;     // running gcd of exponents
    logic                   res_reg, res_next; // pending answer
    logic                   ov_reg, ov_next;   // output valid
    logic                   oa_reg, oa_next;   // output payload

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    ach_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        g_next     = g_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        oa_next    = oa_reg;
        div_start  = 1'b0;

        // downstream takes the pending transaction
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ach_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = value;
                    e_next = '0;
                    g_next = '0;
                    if (value[VALUE_WIDTH-1:1] == '0)
                    begin
                        // zero and one are never Achilles
                        res_next   = 1'b0;
                        state_next = ach_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = ach_pkg::ST_EVEN;
                    end
                end
            end

            ach_pkg::ST_EVEN:
            begin
                if (!n_reg[0])
                begin
                    n_next = {1'b0, n_reg[VALUE_WIDTH-1:1]};
                    e_next = e_reg + EW'(1);
                end
                else if (e_reg == EW'(1))
                begin
                    res_next   = 1'b0;
                    state_next = ach_pkg::ST_FINISH;
                end
                else
                begin
                    // gcd(0, e) = e, and stays 0 when there is no factor two
                    g_next     = e_reg;
                    e_next     = '0;
                    d_next     = VALUE_WIDTH'(ach_pkg::FIRST_ODD_DIV);
                    state_next = ach_pkg::ST_DSTART;
                end
            end

            ach_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ach_pkg::ST_DWAIT;
            end

            ach_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (e_reg != '0)
                    begin
                        // inside the run of one prime: keep dividing while exact
                        if (div_rem == '0)
                        begin
                            n_next     = div_quo;
                            e_next     = e_reg + EW'(1);
                            state_next = ach_pkg::ST_DSTART;
                        end
                        else if (e_reg == EW'(1))
                        begin
                            res_next   = 1'b0;
                            state_next = ach_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = ach_pkg::ST_GCD;
                        end
                    end
                    else if (d_reg > div_quo)
                    begin
                        // search bound passed: leftover cofactor above one is
                        // a single prime
                        res_next   = (n_reg == VALUE_WIDTH'(1)) && (g_reg == EW'(1));
                        state_next = ach_pkg::ST_FINISH;
                    end
                    else if (div_rem == '0)
                    begin
                        n_next     = div_quo;
                        e_next     = EW'(1);
                        state_next = ach_pkg::ST_DSTART;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(ach_pkg::DIV_STEP);
                        state_next = ach_pkg::ST_DSTART;
                    end
                end
            end

            ach_pkg::ST_GCD:
            begin
                // subtractive gcd; e_reg is consumed and ends at zero
                if ((g_reg == '0) || (g_reg == e_reg))
                begin
                    g_next     = e_reg;
                    e_next     = '0;
                    d_next     = d_reg + VALUE_WIDTH'(ach_pkg::DIV_STEP);
                    state_next = ach_pkg::ST_DSTART;
                end
                else if (g_reg > e_reg)
                begin
                    g_next = g_reg - e_reg;
                end
                else
                begin
                    e_next = e_reg - g_reg;
                end
            end

            ach_pkg::ST_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    oa_next    = res_reg;
                    state_next = ach_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ach_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ach_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        g_reg   <= g_next;
        res_reg <= res_next;
        oa_reg  <= oa_next;
    end

    assign in_ready    = (state_reg == ach_pkg::ST_IDLE);
    assign out_valid   = ov_reg;
    assign is_achilles = oa_reg;

endmodule

`default_nettype wire

[rtl/ach_chk.sv]
// Port-level checker for the Achilles number test, with its bind.
`default_nettype none

module ach_chk #(
    parameter int VALUE_WIDTH = ach_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic [VALUE_WIDTH-1:0] value,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   is_achilles
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_achilles))
        else $error("result changed while stalled");

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(value))
        else $error("input changed while stalled");

    // one transaction in flight: taking a value drops ready
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    // ready returns only together with a fresh result
    a_ready_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("ready returned without a result");

endmodule

bind achilles_number_test_top ach_chk #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ach_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_achilles (is_achilles)
);

`default_nettype wire

[tb/achilles_number_test_top_tb.sv]
// Self-checking testbench for achilles_number_test_top: directed and random values.
`timescale 1ns / 1ps

module achilles_number_test_top_tb;

    localparam int VW = ach_pkg::VALUE_WIDTH_DEF;

    // Stimulus sizing
    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 77;
    localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;

    // Random full-width values are kept only if their odd-divisor search is short;
    // each trial costs the block a full divider pass.
    localparam int TRIAL_BUDGET = 300;

    // Sender drains the block completely after these transactions
    localparam int DRAIN_AFTER_A = N_DIRECTED - 1;
    localparam int DRAIN_AFTER_B = N_DIRECTED + 40;

    // Receiver holds out_ready low for a long stretch at this result count
    localparam int LONG_HOLD_AT     = N_DIRECTED + 25;
    localparam int LONG_HOLD_CYCLES = 20000;

    // Watchdog: the largest 31-bit prime needs about 23k divider passes
    // with no handshake at all; the limit leaves a wide margin over that.
    localparam int QUIET_LIMIT  = 3000000;
    localparam int TAIL_CYCLES  = 200;

    // Scoreboard: predicts the verdict of every accepted value and checks results in order
    class achilles_scoreboard;
        logic [VW-1:0] value_q[$];
        bit            verdict_q[$];
        int            n_checked;
        int            n_achilles;
        int            n_errors;

        function longint unsigned exponent_gcd(longint unsigned a, longint unsigned b);
            longint unsigned r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Trial-division classifier; trials counts odd divisors tried
        function bit classify(input logic [VW-1:0] v, output int trials);
            longint unsigned n;
            longint unsigned d;
            longint unsigned e;
            longint unsigned g;
            trials = 0;
            n = v;
            g = 0;
            if (n < 2)
                return 1'b0;
            e = 0;
            while (n[0] == 1'b0) begin
                n = n >> 1;
                e++;
            end
            if (e == 1)
                return 1'b0;
            if (e != 0)
                g = exponent_gcd(g, e);
            d = ach_pkg::FIRST_ODD_DIV;
            while (d <= n / d) begin
                trials++;
                if (n % d == 0) begin
                    e = 0;
                    while (n % d == 0) begin
                        n = n / d;
                        e++;
                    end
                    if (e == 1)
                        return 1'b0;        // prime seen once: not powerful
                    g = exponent_gcd(g, e);
                end
                d += ach_pkg::DIV_STEP;
            end
            if (n > 1)
                return 1'b0;                // leftover prime cofactor
            return (g == 1);                // gcd > 1 means a perfect power
        endfunction

        function void note_value(input logic [VW-1:0] v);
            int trials;
            value_q.push_back(v);
            verdict_q.push_back(classify(v, trials));
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void check_result(input logic got);
            logic [VW-1:0] v;
            bit            want;
            if (verdict_q.size() == 0) begin
                $error("is_achilles: no transaction pending, actual %0b", got);
                n_errors++;
                return;
            end
            v    = value_q.pop_front();
            want = verdict_q.pop_front();
            n_checked++;
            if (want)
                n_achilles++;
            if (got !== want) begin
                $error("is_achilles (value %0d): expected %0b, actual %0b", v, want, got);
                n_errors++;
            end
        endfunction
    endclass

    // DUT inputs driven to known values from time zero
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic [VW-1:0] value     = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic          is_achilles;

    achilles_scoreboard sb = new();

    // Zero and one, small powerful numbers and perfect powers, primes seen once
    // (including a leftover prime cofactor), big values, most with the top bit set,
    // and last the largest value, which is prime and the slowest case.
    logic [VW-1:0] directed_vals [N_DIRECTED] = '{
        0, 1, 2, 3, 4, 8, 12, 16, 36, 72, 108, 180, 200, 324, 500, 675, 1800, 3636,
        715827882, 1207959552, 1162261467, 1073741824, 2147483647
    };

    int small_primes [25] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
        53, 59, 61, 67, 71, 73, 79, 83, 89, 97
    };

    achilles_number_test_top #(
        .VALUE_WIDTH (VW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_achilles (is_achilles)
    );

    always #10 clk = ~clk;

    // Idle cycles before a transaction; every fourth run of 12 has none at all
    function automatic int idle_gap(input int idx);
        if ((idx / 12) % 4 == 3)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Random value. Most often powerful numbers built from small prime powers (some
    // forced to perfect powers, some spoiled by an extra odd factor), then plain
    // perfect powers, cheap full-width values and small values.
    function automatic logic [VW-1:0] pick_value();
        longint unsigned lim;
        longint unsigned n;
        longint unsigned pk;
        longint unsigned q;
        int              mode;
        int              pw;
        int              e;
        int              trials;
        bit              verdict;
        lim  = longint'(1) << VW;
        mode = $urandom_range(0, 9);
        if (mode <= 3) begin
            n  = 1;
            pw = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
            foreach (small_primes[j]) begin
                if ($urandom_range(0, 2) == 0) begin
                    e  = (pw > 1) ? pw * $urandom_range(1, 3) : $urandom_range(2, 6);
                    pk = 1;
                    repeat (e) pk = pk * small_primes[j];
                    if (pk < lim && n * pk < lim)
                        n = n * pk;
                end
            end
            if (n == 1)
                n = 72;
            if ($urandom_range(0, 4) == 0) begin
                q = $urandom_range(3, 2001) | 1;
                if (n * q < lim)
                    n = n * q;
            end
        end
        else if (mode == 4) begin
            q = $urandom_range(2, 1000);
            n = 1;
            repeat ($urandom_range(2, 5)) begin
                if (n * q < lim)
                    n = n * q;
            end
        end
        else if (mode <= 6) begin
            do begin
                n = $urandom;
                n = n & (lim - 1);
                verdict = sb.classify(n[VW-1:0], trials);
            end while (trials > TRIAL_BUDGET);
        end
        else begin
            n = $urandom_range(1, 1 << $urandom_range(4, 16));
        end
        return n[VW-1:0];
    endfunction

    // Offer one transaction and hold it until taken. in_valid drops after the
    // handshake only if a gap follows or the caller asks for it.
    task automatic send_value(input logic [VW-1:0] v, input int gap_after, input bit drop);
        in_valid <= 1'b1;
        value    <= v;
        do @(negedge clk); while (in_ready !== 1'b1);
        @(posedge clk);
        sb.note_value(v);
        if (drop || gap_after > 0)
            in_valid <= 1'b0;
        repeat (gap_after) @(posedge clk);
    endtask

    // Sender
    initial begin : value_source
        logic [VW-1:0] v;
        int            gap;
        bit            drain;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_ITEMS; i++) begin
            v     = (i < N_DIRECTED) ? directed_vals[i] : pick_value();
            drain = (i == DRAIN_AFTER_A) || (i == DRAIN_AFTER_B) || (i == N_ITEMS - 1);
            gap   = drain ? 0 : idle_gap(i + 1);
            send_value(v, gap, drain);
            // Pause the sender until the block has returned every verdict
            if (drain) begin
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        // Give a stray extra result time to show up
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Classified %0d values (%0d Achilles): %0d directed edge cases, %0d random",
                 sb.n_checked, sb.n_achilles, N_DIRECTED, N_RANDOM);
        $display("Random idling on both sides, three full drains, one %0d-cycle output stall.",
                 LONG_HOLD_CYCLES);
        if (sb.n_errors == 0)
            $display("** achilles_number_test_top: PASSED **");
        else
            $display("** achilles_number_test_top: FAILED **");
        $finish;
    end

    // Receiver: random stalls, plus one long hold so the block backs up into its input
    initial begin : verdict_sink
        int   gap;
        int   n_results;
        logic got;
        n_results = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            gap = (n_results == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : idle_gap(n_results);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (out_valid !== 1'b1);
            got = is_achilles;
            @(posedge clk);
            sb.check_result(got);
            n_results++;
        end
    end

    // Watchdog: cycles with no transaction on either channel
    int quiet_cycles = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d verdicts pending",
                         quiet_cycles, sb.pending());
                $display("** achilles_number_test_top: FAILED **");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
rtl/ach_pkg.sv
rtl/ach_div.sv
rtl/achilles_number_test_top.sv
rtl/ach_chk.sv
tb/achilles_number_test_top_tb.sv
